// ===== hdl/lcdd_pkg.sv =====
// ----------------------------------------------------------------------------
// LCD numeric driver package
// Command codes, the queued command word and the seven-segment table.
// ----------------------------------------------------------------------------
package lcdd_pkg;

	localparam int NUM_POS = 6;
	localparam int VAL_W   = 20;

	// Incoming function codes
	localparam logic [2:0] FUNC_RADIO  = 3'd0;
	localparam logic [2:0] FUNC_TWOWAY = 3'd1;
	localparam logic [2:0] FUNC_DOT    = 3'd2;
	localparam logic [2:0] FUNC_ALLDOT = 3'd3;
	localparam logic [2:0] FUNC_TEST   = 3'd4;

	localparam logic [23:0] RADIO_MAX  = 24'd999999;
	localparam logic [23:0] TWOWAY_MAX = 24'd9999;
	localparam logic [VAL_W-1:0] TEST_VALUE = 20'd888888;

	localparam logic [7:0] DOT_MASK      = 8'h10;
	localparam logic [7:0] BLANK_PATTERN = 8'h00;

	// Classified operations carried through the queue
	typedef enum logic [2:0] {
		OP_RADIO  = 3'd0,
		OP_TWOWAY = 3'd1,
		OP_DOT    = 3'd2,
		OP_ALLDOT = 3'd3,
		OP_TEST   = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [VAL_W-1:0] value;
		logic             enable;
		logic [2:0]       position;
	} cmd_t;

	function automatic logic [7:0] seg_pattern(input logic [3:0] d);
		logic [7:0] p;
		unique case (d)
			4'd0: p = 8'b11101011;
			4'd1: p = 8'b01100000;
			4'd2: p = 8'b11000111;
			4'd3: p = 8'b11100101;
			4'd4: p = 8'b01101100;
			4'd5: p = 8'b10101101;
			4'd6: p = 8'b10101111;
			4'd7: p = 8'b11100000;
			4'd8: p = 8'b11101111;
			4'd9: p = 8'b11101101;
			default: p = BLANK_PATTERN;
		endcase
		return p;
	endfunction

endpackage

// ===== hdl/lcdd_front.sv =====
// ----------------------------------------------------------------------------
// LCD driver front end
// Accepts command words, clamps and classifies them, and queues them.
// ----------------------------------------------------------------------------
module lcdd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [2:0]     func,
	input  logic [23:0]    value,
	input  logic           enable,
	input  logic [2:0]     position,
	output logic           q_valid,
	output lcdd_pkg::cmd_t q_cmd,
	input  logic           q_pop
);
	import lcdd_pkg::*;

	cmd_t       ent_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       keep;
	logic       push;

	// Classify: clamp the value, drop commands that cause no write
	always_comb begin
		cls.op       = OP_RADIO;
		cls.value    = '0;
		cls.enable   = enable;
		cls.position = position;
		keep         = 1'b1;
		unique case (func)
			FUNC_RADIO: begin
				cls.op    = OP_RADIO;
				cls.value = (value > RADIO_MAX) ? RADIO_MAX[VAL_W-1:0] : value[VAL_W-1:0];
			end
			FUNC_TWOWAY: begin
				cls.op    = OP_TWOWAY;
				cls.value = (value > TWOWAY_MAX) ? TWOWAY_MAX[VAL_W-1:0] : value[VAL_W-1:0];
			end
			FUNC_DOT: begin
				cls.op = OP_DOT;
				keep   = (position < 3'(NUM_POS));
			end
			FUNC_ALLDOT: cls.op = OP_ALLDOT;
			FUNC_TEST: begin
				cls.op    = enable ? OP_TEST : OP_CLEAR;
				cls.value = TEST_VALUE;
			end
			default: keep = 1'b0;
		endcase
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready && keep;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_cmd    = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

// ===== hdl/lcdd_back.sv =====
// ----------------------------------------------------------------------------
// LCD driver back end
// Sequences the controller writes of one command and keeps the segment image.
// ----------------------------------------------------------------------------
module lcdd_back #(
	parameter int CONTROLLER_ADDRESSES = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  lcdd_pkg::cmd_t q_cmd,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [4:0]     ram_address,
	output logic [7:0]     write_data,
	output logic           write_width,
	output logic           last
);
	import lcdd_pkg::*;

	localparam int CLR_COUNT = (CONTROLLER_ADDRESSES > 32) ? 32 : CONTROLLER_ADDRESSES;
	localparam logic [4:0] CLR_LAST = 5'(CLR_COUNT - 1);
	// ceil(2^23 / 10): exact quotient for values below 2^22
	localparam logic [39:0] RECIP = 40'd838861;

	typedef enum logic [1:0] {
		K_PAT = 2'd0,
		K_DOT = 2'd1,
		K_NIB = 2'd2
	} kind_t;

	logic [7:0]       img_q [NUM_POS];
	logic             busy_q;
	op_t              op_q;
	logic [VAL_W-1:0] v_q;
	logic             en_q;
	logic [2:0]       pos_q;
	logic [4:0]       step_q;

	logic             out_valid_q;
	logic [4:0]       addr_q;
	logic [7:0]       data_q;
	logic             width_q;
	logic             last_q;

	logic [39:0]      prod;
	logic [VAL_W-1:0] quot;
	logic [VAL_W-1:0] rem;
	logic [7:0]       digit_pat;

	kind_t            kind;
	logic [2:0]       pos;
	logic [7:0]       pattern;
	logic             dot_on;
	logic             is_last;
	logic [7:0]       new_byte;
	logic             fire;

	// Peel off the low decimal digit
	assign prod      = 40'(v_q) * RECIP;
	assign quot      = VAL_W'(prod[39:23]);
	assign rem       = v_q - ((quot << 3) + (quot << 1));
	assign digit_pat = seg_pattern(rem[3:0]);

	always_comb begin
		kind    = K_NIB;
		pos     = 3'd0;
		pattern = BLANK_PATTERN;
		dot_on  = 1'b0;
		is_last = 1'b0;
		unique case (op_q)
			OP_RADIO, OP_TEST: begin
				if (step_q < 5'd6) begin
					kind    = K_PAT;
					pos     = 3'd5 - step_q[2:0];
					pattern = digit_pat;
				end else if (op_q == OP_RADIO) begin
					kind    = K_DOT;
					pos     = 3'd2;
					dot_on  = 1'b1;
					is_last = 1'b1;
				end else begin
					kind    = K_DOT;
					pos     = 3'(step_q - 5'd6);
					dot_on  = 1'b1;
					is_last = (step_q == 5'd11);
				end
			end
			OP_TWOWAY: begin
				if (step_q < 5'd4) begin
					kind    = K_PAT;
					pos     = 3'd4 - step_q[2:0];
					pattern = digit_pat;
				end else if (step_q == 5'd4) begin
					kind = K_PAT;
					pos  = 3'd0;
				end else if (step_q == 5'd5) begin
					kind = K_PAT;
					pos  = 3'd5;
				end else begin
					kind    = K_DOT;
					pos     = 3'd2;
					is_last = 1'b1;
				end
			end
			OP_DOT: begin
				kind    = K_DOT;
				pos     = pos_q;
				dot_on  = en_q;
				is_last = 1'b1;
			end
			OP_ALLDOT: begin
				kind    = K_DOT;
				pos     = step_q[2:0];
				dot_on  = en_q;
				is_last = (step_q == 5'd5);
			end
			OP_CLEAR: begin
				kind    = K_NIB;
				is_last = (step_q == CLR_LAST);
			end
			default: begin
				kind    = K_NIB;
				is_last = 1'b1;
			end
		endcase
	end

	assign new_byte = (kind == K_PAT) ? pattern
	                : ((img_q[pos] & ~DOT_MASK) | (dot_on ? DOT_MASK : 8'h00));
	assign fire     = busy_q && (!out_valid_q || out_ready);
	assign q_pop    = !busy_q && q_valid;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q  <= q_cmd.op;
			v_q   <= q_cmd.value;
			en_q  <= q_cmd.enable;
			pos_q <= q_cmd.position;
		end else if (fire) begin
			v_q <= quot;
		end
		if (fire) begin
			addr_q  <= (kind == K_NIB) ? step_q : {1'b0, pos, 1'b0};
			data_q  <= (kind == K_NIB) ? 8'h00 : new_byte;
			width_q <= (kind != K_NIB);
			last_q  <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= 5'd0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_POS; i++) begin
				img_q[i] <= 8'h00;
			end
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				step_q <= 5'd0;
			end else if (fire) begin
				step_q <= step_q + 5'd1;
				if (is_last) begin
					busy_q <= 1'b0;
				end
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (fire) begin
				if (kind == K_NIB) begin
					for (int i = 0; i < NUM_POS; i++) begin
						img_q[i] <= 8'h00;
					end
				end else begin
					img_q[pos] <= new_byte;
				end
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign ram_address = addr_q;
	assign write_data  = data_q;
	assign write_width = width_q;
	assign last        = last_q;

	a_nib_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !width_q |-> data_q == 8'h00)
		else $error("nibble write with nonzero data");

	a_byte_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && width_q |-> !addr_q[0] && addr_q <= 5'd10)
		else $error("byte write outside digit addresses");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_last |=> !busy_q && last_q)
		else $error("sequencer busy after final write");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !q_pop)
		else $error("queue popped while a command is running");

endmodule

// ===== hdl/segment_lcd_numeric_display_driver_core.sv =====
// ----------------------------------------------------------------------------
// Segment LCD numeric display driver
// Turns display commands into the controller RAM writes of a six-digit LCD.
// ----------------------------------------------------------------------------
// A word accepted into the queue is loaded by the sequencer when the sequencer
// is idle; the sequencer then registers its first write on the output.
// Throughput: one write per cycle while the receiver is ready; the sequencer
// loads a new command only after the final write of the current one.
// Two commands queue while one runs, so input and output stall independently.
// Reset: the segment image clears to blank, the queue empties, no write shown.
// ----------------------------------------------------------------------------
module segment_lcd_numeric_display_driver_core #(
	parameter int CONTROLLER_ADDRESSES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [23:0] value,
	input  logic        enable,
	input  logic [2:0]  position,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  ram_address,
	output logic [7:0]  write_data,
	output logic        write_width,
	output logic        last
);
	import lcdd_pkg::*;

	// Queue handoff between front end and sequencer
	logic q_valid;
	cmd_t q_cmd;
	logic q_pop;

	// Front: accept words while the queue has room, clamp the value, drop no-op commands
	lcdd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.value    (value),
		.enable   (enable),
		.position (position),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop)
	);

	// Back: step through the writes and update the segment image
	lcdd_back #(
		.CONTROLLER_ADDRESSES (CONTROLLER_ADDRESSES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_cmd       (q_cmd),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.ram_address (ram_address),
		.write_data  (write_data),
		.write_width (write_width),
		.last        (last)
	);

endmodule

// ===== tb/sv/lcdd_write_checker.sv =====
// ----------------------------------------------------------------------------
// LCD driver write checker
// Watches both channels of the display driver. It predicts the controller
// writes that each accepted command word causes and compares every accepted
// write with the oldest one still expected.
// ----------------------------------------------------------------------------
module lcdd_write_checker #(
	parameter int CONTROLLER_ADDRESSES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  func,
	input  logic [23:0] value,
	input  logic        enable,
	input  logic [2:0]  position,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [4:0]  ram_address,
	input  logic [7:0]  write_data,
	input  logic        write_width,
	input  logic        last,
	output int unsigned pending,
	output int unsigned fail_count
);
	import lcdd_pkg::*;

	localparam logic WIDTH_NIBBLE = 1'b0;
	localparam logic WIDTH_BYTE   = 1'b1;
	localparam int   MAX_WRITES   = 32;

	typedef struct packed {
		logic [4:0] addr;
		logic [7:0] data;
		logic       width;
		logic       last;
	} lcd_write_t;

	lcd_write_t lcd_writes_q[$];
	lcd_write_t cmd_writes_q[$];
	logic [7:0] seg_image [NUM_POS];

	initial begin
		pending    = 0;
		fail_count = 0;
	end

	function automatic logic [7:0] digit_segments(input int unsigned d);
		case (d)
			0: return 8'hEB;
			1: return 8'h60;
			2: return 8'hC7;
			3: return 8'hE5;
			4: return 8'h6C;
			5: return 8'hAD;
			6: return 8'hAF;
			7: return 8'hE0;
			8: return 8'hEF;
			default: return 8'hED;
		endcase
	endfunction

	task automatic add_write(input logic [4:0] a, input logic [7:0] d, input logic w);
		lcd_write_t wr;
		wr.addr  = a;
		wr.data  = d;
		wr.width = w;
		wr.last  = 1'b0;
		if (cmd_writes_q.size() < MAX_WRITES)
			cmd_writes_q.push_back(wr);
	endtask

	task automatic post_position(input int p);
		add_write(5'(p * 2), seg_image[p], WIDTH_BYTE);
	endtask

	task automatic put_pattern(input int p, input logic [7:0] pat);
		seg_image[p] = pat;
		post_position(p);
	endtask

	task automatic put_dot(input int p, input logic on);
		seg_image[p] = (seg_image[p] & ~DOT_MASK) | (on ? DOT_MASK : 8'h00);
		post_position(p);
	endtask

	task automatic show_six_digits(input int unsigned v);
		int p;
		if (v > 999999)
			v = 999999;
		for (p = NUM_POS - 1; p >= 0; p--) begin
			put_pattern(p, digit_segments(v % 10));
			v = v / 10;
		end
	endtask

	task automatic clear_display();
		int n;
		int a;
		n = (CONTROLLER_ADDRESSES > MAX_WRITES) ? MAX_WRITES : CONTROLLER_ADDRESSES;
		for (a = 0; a < n; a++)
			add_write(5'(a), 8'h00, WIDTH_NIBBLE);
		for (a = 0; a < NUM_POS; a++)
			seg_image[a] = BLANK_PATTERN;
	endtask

	task automatic predict_writes(input logic [2:0] f, input logic [23:0] v,
			input logic en, input logic [2:0] pos);
		int unsigned tv;
		int q;
		cmd_writes_q.delete();
		case (f)
			FUNC_RADIO: begin
				show_six_digits(v);
				put_dot(2, 1'b1);
			end
			FUNC_TWOWAY: begin
				tv = (v > TWOWAY_MAX) ? 9999 : v;
				for (q = 4; q >= 1; q--) begin
					put_pattern(q, digit_segments(tv % 10));
					tv = tv / 10;
				end
				put_pattern(0, BLANK_PATTERN);
				put_pattern(5, BLANK_PATTERN);
				put_dot(2, 1'b0);
			end
			FUNC_DOT: begin
				if (pos < NUM_POS)
					put_dot(pos, en);
			end
			FUNC_ALLDOT: begin
				for (q = 0; q < NUM_POS; q++)
					put_dot(q, en);
			end
			FUNC_TEST: begin
				if (en) begin
					show_six_digits(888888);
					for (q = 0; q < NUM_POS; q++)
						put_dot(q, 1'b1);
				end else begin
					clear_display();
				end
			end
			default: ;
		endcase
		if (cmd_writes_q.size() > 0)
			cmd_writes_q[cmd_writes_q.size() - 1].last = 1'b1;
		foreach (cmd_writes_q[i])
			lcd_writes_q.push_back(cmd_writes_q[i]);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		lcd_write_t exp_wr;
		if (!arst_n) begin
			lcd_writes_q.delete();
			foreach (seg_image[i])
				seg_image[i] = BLANK_PATTERN;
			pending <= 0;
		end else begin
			// check the write first, then queue what the new word causes
			if (out_valid && out_ready) begin
				if (lcd_writes_q.size() == 0) begin
					report_mismatch("unexpected write address", ram_address, 0);
				end else begin
					exp_wr = lcd_writes_q.pop_front();
					if (ram_address !== exp_wr.addr)
						report_mismatch("ram_address", ram_address, exp_wr.addr);
					if (write_data !== exp_wr.data)
						report_mismatch("write_data", write_data, exp_wr.data);
					if (write_width !== exp_wr.width)
						report_mismatch("write_width", write_width, exp_wr.width);
					if (last !== exp_wr.last)
						report_mismatch("last", last, exp_wr.last);
				end
			end
			if (in_valid && in_ready)
				predict_writes(func, value, enable, position);
			pending <= lcd_writes_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_segment_lcd_numeric_display_driver_core.sv =====
// ----------------------------------------------------------------------------
// Segment LCD numeric display driver testbench
// Sends directed and random display commands with random idle bursts on both
// channels; a checker beside the block predicts and compares every write.
// ----------------------------------------------------------------------------
module tb_segment_lcd_numeric_display_driver_core;
	import lcdd_pkg::*;

	localparam int         CONTROLLER_ADDRESSES = 32;
	localparam int         MAX_CYCLES           = 600000;
	localparam int         RANDOM_WORDS         = 160;
	localparam int         PRESSURE_AT          = 80;
	localparam int         QUIET_AT             = 135;
	localparam int         DRAIN_CYCLES         = 40;
	// function codes the block ignores
	localparam logic [2:0] FUNC_NONE_FIRST      = 3'd5;
	localparam logic [2:0] FUNC_NONE_LAST       = 3'd7;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [2:0]  func        = FUNC_RADIO;
	logic [23:0] value       = 24'd0;
	logic        enable      = 1'b0;
	logic [2:0]  position    = 3'd0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [4:0]  ram_address;
	logic [7:0]  write_data;
	logic        write_width;
	logic        last;

	int unsigned pending;
	int unsigned fail_count;
	int unsigned cycle_count = 0;
	int unsigned stall_left  = 0;
	logic        quiet       = 1'b0;

	segment_lcd_numeric_display_driver_core #(
		.CONTROLLER_ADDRESSES(CONTROLLER_ADDRESSES)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.value      (value),
		.enable     (enable),
		.position   (position),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ram_address(ram_address),
		.write_data (write_data),
		.write_width(write_width),
		.last       (last)
	);

	lcdd_write_checker #(
		.CONTROLLER_ADDRESSES(CONTROLLER_ADDRESSES)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.value      (value),
		.enable     (enable),
		.position   (position),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ram_address(ram_address),
		.write_data (write_data),
		.write_width(write_width),
		.last       (last),
		.pending    (pending),
		.fail_count (fail_count)
	);

	always #10 clk = ~clk;

	// Abort a hung run: nothing correct takes anywhere near this long.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= MAX_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver: hold out_ready low in random bursts, and drop
	// the bursts once the quiet tail of the run begins.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(0, 15);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Present one command word and hold it until the handshake; then either
	// keep valid high for the next word or idle for a random burst.
	task automatic send_word(input logic [2:0] f, input logic [23:0] v,
			input logic en, input logic [2:0] pos);
		in_valid <= 1'b1;
		func     <= f;
		value    <= v;
		enable   <= en;
		position <= pos;
		do @(posedge clk); while (!in_ready);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// Mix small numbers, values around both clamp limits and the full range.
	function automatic logic [23:0] pick_value();
		case ($urandom_range(0, 4))
			0: return 24'($urandom_range(0, 20));
			1: return 24'($urandom_range(999990, 1000010));
			2: return 24'($urandom_range(9990, 10010));
			3: return 24'($urandom_range(0, 9999));
			default: return 24'($urandom());
		endcase
	endfunction

	initial begin
		int unsigned counted;
		int unsigned pick;
		logic [2:0]  f;
		logic [2:0]  pos;
		logic        paused;

		counted = 0;
		paused  = 1'b0;

		// hold reset low, then release it on a clock edge
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: limits of both number modes, every dot case, test and
		// clear, ignored dot positions and unused function codes.
		send_word(FUNC_RADIO,  24'd0,       1'b0, 3'd0);
		send_word(FUNC_RADIO,  24'd999999,  1'b1, 3'd7);
		send_word(FUNC_RADIO,  24'd1000000, 1'b0, 3'd3);
		send_word(FUNC_RADIO,  24'hFFFFFF,  1'b1, 3'd5);
		send_word(FUNC_RADIO,  24'd123456,  1'b0, 3'd1);
		send_word(FUNC_TWOWAY, 24'd0,       1'b1, 3'd2);
		send_word(FUNC_TWOWAY, 24'd9999,    1'b0, 3'd0);
		send_word(FUNC_TWOWAY, 24'd10000,   1'b1, 3'd6);
		send_word(FUNC_TWOWAY, 24'hFFFFFF,  1'b0, 3'd4);
		send_word(FUNC_TWOWAY, 24'd4321,    1'b1, 3'd7);
		send_word(FUNC_DOT,    24'hFFFFFF,  1'b1, 3'd0);
		send_word(FUNC_DOT,    24'd0,       1'b0, 3'd5);
		send_word(FUNC_DOT,    24'd77,      1'b1, 3'd2);
		send_word(FUNC_DOT,    24'd0,       1'b1, 3'd6);
		send_word(FUNC_DOT,    24'd0,       1'b1, 3'd7);
		send_word(FUNC_ALLDOT, 24'd5,       1'b1, 3'd7);
		send_word(FUNC_ALLDOT, 24'hFFFFFF,  1'b0, 3'd0);
		send_word(FUNC_TEST,   24'd0,       1'b1, 3'd0);
		send_word(FUNC_DOT,    24'd0,       1'b0, 3'd2);
		send_word(FUNC_TEST,   24'hFFFFFF,  1'b0, 3'd7);
		send_word(FUNC_DOT,    24'd0,       1'b1, 3'd3);
		send_word(FUNC_NONE_FIRST, 24'hFFFFFF, 1'b1, 3'd7);
		send_word(FUNC_NONE_LAST,  24'd0,      1'b0, 3'd0);
		send_word(FUNC_TEST,   24'd0,       1'b0, 3'd1);

		// Random: count only words that cause writes.
		while (counted < RANDOM_WORDS) begin
			pick = $urandom_range(0, 99);
			pos  = 3'($urandom_range(0, 7));
			if (pick < 25)
				f = FUNC_RADIO;
			else if (pick < 45)
				f = FUNC_TWOWAY;
			else if (pick < 70)
				f = FUNC_DOT;
			else if (pick < 80)
				f = FUNC_ALLDOT;
			else if (pick < 93)
				f = FUNC_TEST;
			else
				f = 3'($urandom_range(FUNC_NONE_FIRST, FUNC_NONE_LAST));

			send_word(f, pick_value(), 1'($urandom_range(0, 1)), pos);
			if (f <= FUNC_TEST && !(f == FUNC_DOT && pos >= NUM_POS))
				counted++;

			// once, starve the block: hold off until every write is out
			if (!paused && counted >= PRESSURE_AT) begin
				paused = 1'b1;
				in_valid <= 1'b0;
				do @(posedge clk); while (pending != 0);
			end

			// drop all idling for the tail of the run
			if (counted >= QUIET_AT)
				quiet <= 1'b1;
		end

		// drain: wait for every expected write, then let the block settle
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/lcdd_pkg.sv
hdl/lcdd_front.sv
hdl/lcdd_back.sv
hdl/segment_lcd_numeric_display_driver_core.sv
tb/sv/lcdd_write_checker.sv
tb/sv/tb_segment_lcd_numeric_display_driver_core.sv
